FILE: rtl/fat16_cluster_chain_sector_walker_macros.svh
// Assertion macros used by the checker file of the cluster chain walker.
// Depends on nothing; the using scope must provide i_clk and i_rst_n.
`ifndef FAT16_CLUSTER_CHAIN_SECTOR_WALKER_MACROS_SVH
`define FAT16_CLUSTER_CHAIN_SECTOR_WALKER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/fcw_pkg.sv
// Shared types and constants of the FAT16 cluster chain walker.
// Depends on nothing; every RTL file but fcw_ram and the macro header imports it.
package fcw_pkg;

    localparam int CMD_W = 2;
    localparam int IDX_W = 14;
    localparam int VAL_W = 16;
    localparam int CLU_W = 16;
    localparam int SEC_W = 32;
    localparam int ST_W  = 2;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [VAL_W-1:0] END_MARK  = 16'hFFFF;
    localparam logic [VAL_W-1:0] FREE_MARK = 16'h0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_START   = 2'd1,
        CMD_ADVANCE = 2'd2
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 2'd0,
        ST_NO_CHAIN    = 2'd1,
        ST_BAD_CLUSTER = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        REG_HIDDEN   = 3'd0,
        REG_RESERVED = 3'd1,
        REG_FAT_SIZE = 3'd2,
        REG_FAT_NUM  = 3'd3,
        REG_ROOT_ENT = 3'd4,
        REG_SPC      = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_LOOK,
        S_EMIT,
        S_REJECT
    } t_state;

    // Volume geometry as held in the configuration registers
    typedef struct packed {
        logic [31:0] hidden;
        logic [15:0] reserved;
        logic [15:0] fat_size;
        logic [7:0]  fat_copies;
        logic [15:0] root_entries;
        logic [7:0]  spc;
    } t_geom;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic start;
        logic wr_en;
        logic rd_en;
        logic emit;
        logic reject;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic active;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/fcw_if.sv
// Valid/ready channel interfaces for command items and chain results.
// Depends on fcw_pkg for field widths.
interface fcw_in_if;
    import fcw_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
    logic [CLU_W-1:0] first_cluster;

    modport source (output valid, command, entry_index, entry_value, first_cluster,
                    input ready);
    modport sink   (input valid, command, entry_index, entry_value, first_cluster,
                    output ready);
endinterface

interface fcw_out_if;
    import fcw_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEC_W-1:0] sector;
    logic [CLU_W-1:0] cluster;
    logic             last;
    logic [ST_W-1:0]  status;

    modport source (output valid, sector, cluster, last, status, input ready);
    modport sink   (input valid, sector, cluster, last, status, output ready);
endinterface

FILE: rtl/fat16_cluster_chain_sector_walker.sv
// FAT16 cluster chain walker. Holds an allocation table of TABLE_ENTRIES
// 16-bit entries in a single RAM, filled by write-entry commands. A start
// command loads the file's first cluster and returns one result: the first
// sector of that cluster (hidden + reserved + table size * copies +
// root entries / 16 + (cluster - 2) * sectors per cluster, modulo 2^32), the
// cluster number and a last flag; each advance command then returns the
// next cluster of the chain. A table entry of 0xFFFF or 0x0000 ends the
// chain. A cluster below 2 or beyond the table returns bad-cluster status
// with sector 0 and ends the chain; an advance with no chain in progress
// returns no-chain status with all fields zero. Write-entry commands and the
// unused command code return nothing; writes beyond the table are dropped.
// Steps: a write-entry command goes through transfer and RAM write; start
// and an advance on an active chain go through transfer, table RAM read and
// result load, since the result needs the registered RAM read of the current
// cluster's entry; an advance with no chain goes through transfer and result
// load, and the unused command code through transfer alone. The result
// register frees the input side: the next command transfer is taken while a
// result waits, and a following result holds in the load step until the
// sink takes the previous one. Table contents are undefined after reset:
// read only entries written since reset; there is no clearing pass.
// Geometry registers sit on the APB port at byte address 4*index; the user
// must see that they are written only while the block is idle, which the
// block does not enforce. The sector base follows writes via r_fat_sec.
module fat16_cluster_chain_sector_walker #(
    parameter int TABLE_ENTRIES = 16384
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcw_pkg::APB_AW-1:0] paddr,
    input  logic [fcw_pkg::APB_DW-1:0] pwdata,
    output logic [fcw_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    fcw_in_if.sink                     i_item,
    fcw_out_if.source                  o_result
);
    import fcw_pkg::*;

    t_geom    w_geom;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Geometry registers
    fcw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (w_geom)
    );

    // Sequencer: decode the command on transfer, then step write or lookup
    fcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_item.valid),
        .i_command (i_item.command),
        .o_ready   (i_item.ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Table RAM, chain state, sector arithmetic and the result register
    fcw_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_geom          (w_geom),
        .i_entry_index   (i_item.entry_index),
        .i_entry_value   (i_item.entry_value),
        .i_first_cluster (i_item.first_cluster),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_sector        (o_result.sector),
        .o_cluster       (o_result.cluster),
        .o_last          (o_result.last),
        .o_status        (o_result.status)
    );
endmodule

FILE: rtl/fcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/fcw_cfg.sv
// APB register file holding the volume geometry.
// Depends on fcw_pkg.
module fcw_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcw_pkg::APB_AW-1:0] paddr,
    input  logic [fcw_pkg::APB_DW-1:0] pwdata,
    output logic [fcw_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output fcw_pkg::t_geom             o_geom
);
    import fcw_pkg::*;

    t_geom    r_geom;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_geom = r_geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.hidden       <= 32'd0;
            r_geom.reserved     <= 16'd1;
            r_geom.fat_size     <= 16'd0;
            r_geom.fat_copies   <= 8'd2;
            r_geom.root_entries <= 16'd512;
            r_geom.spc          <= 8'd1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HIDDEN:   r_geom.hidden       <= pwdata;
                REG_RESERVED: r_geom.reserved     <= pwdata[15:0];
                REG_FAT_SIZE: r_geom.fat_size     <= pwdata[15:0];
                REG_FAT_NUM:  r_geom.fat_copies   <= pwdata[7:0];
                REG_ROOT_ENT: r_geom.root_entries <= pwdata[15:0];
                REG_SPC:      r_geom.spc          <= pwdata[7:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_HIDDEN:   prdata = r_geom.hidden;
            REG_RESERVED: prdata = {16'd0, r_geom.reserved};
            REG_FAT_SIZE: prdata = {16'd0, r_geom.fat_size};
            REG_FAT_NUM:  prdata = {24'd0, r_geom.fat_copies};
            REG_ROOT_ENT: prdata = {16'd0, r_geom.root_entries};
            REG_SPC:      prdata = {24'd0, r_geom.spc};
            default:      prdata = '0;
        endcase
    end
endmodule

FILE: rtl/fcw_ctrl.sv
// Controller state machine: sequences table writes, table lookups and results.
// Depends on fcw_pkg.
module fcw_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [fcw_pkg::CMD_W-1:0] i_command,
    output logic                      o_ready,
    input  fcw_pkg::t_dp_stat         i_stat,
    output fcw_pkg::t_dp_cmd          o_cmd
);
    import fcw_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    assign w_cmd = t_cmd'(i_command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (w_cmd)
                        CMD_WRITE:   n_state = S_WRITE;
                        CMD_START:   n_state = S_LOOK;
                        CMD_ADVANCE: n_state = i_stat.active ? S_LOOK : S_REJECT;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE:  n_state = S_IDLE;
            S_LOOK:   n_state = S_EMIT;
            S_EMIT:   n_state = i_stat.out_free ? S_IDLE : S_EMIT;
            S_REJECT: n_state = i_stat.out_free ? S_IDLE : S_REJECT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
                o_cmd.start   = i_valid && (w_cmd == CMD_START);
            end
            S_WRITE:  o_cmd.wr_en  = 1'b1;
            S_LOOK:   o_cmd.rd_en  = 1'b1;
            S_EMIT:   o_cmd.emit   = i_stat.out_free;
            S_REJECT: o_cmd.reject = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

FILE: rtl/fcw_dp.sv
// Datapath: allocation table memory, chain registers, sector arithmetic and
// result register. Depends on fcw_pkg and fcw_ram.
module fcw_dp #(
    parameter int TABLE_ENTRIES = 16384
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fcw_pkg::t_dp_cmd          i_cmd,
    output fcw_pkg::t_dp_stat         o_stat,
    input  fcw_pkg::t_geom            i_geom,
    input  logic [fcw_pkg::IDX_W-1:0] i_entry_index,
    input  logic [fcw_pkg::VAL_W-1:0] i_entry_value,
    input  logic [fcw_pkg::CLU_W-1:0] i_first_cluster,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [fcw_pkg::SEC_W-1:0] o_sector,
    output logic [fcw_pkg::CLU_W-1:0] o_cluster,
    output logic                      o_last,
    output logic [fcw_pkg::ST_W-1:0]  o_status
);
    import fcw_pkg::*;

    localparam int          AW          = $clog2(TABLE_ENTRIES);
    localparam logic [16:0] TABLE_LIMIT = 17'(TABLE_ENTRIES);

    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;
    logic [CLU_W-1:0] r_cur;
    logic [CLU_W-1:0] n_cur;
    logic             r_active;
    logic             n_active;
    logic             r_bad;
    logic [23:0]      r_prod;
    logic [23:0]      r_fat_sec;
    logic [31:0]      r_base;

    logic             r_out_valid;
    logic             n_out_valid;
    logic [SEC_W-1:0] r_sector;
    logic [CLU_W-1:0] r_cluster;
    logic             r_last;
    t_status          r_status;

    logic [16:0]      w_idx_ext;
    logic             w_idx_ok;
    logic             w_cur_bad;
    logic [CLU_W-1:0] w_cl_off;
    logic [VAL_W-1:0] w_rdata;
    logic             w_is_last;
    logic             w_out_free;

    assign w_idx_ext  = {3'd0, r_idx};
    assign w_idx_ok   = w_idx_ext < TABLE_LIMIT;
    assign w_cur_bad  = (r_cur < 16'd2) || ({1'b0, r_cur} >= TABLE_LIMIT);
    assign w_cl_off   = r_cur - 16'd2;
    assign w_is_last  = (w_rdata == END_MARK) || (w_rdata == FREE_MARK);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_stat.active   = r_active;
    assign o_stat.out_free = w_out_free;

    fcw_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en && w_idx_ok),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (r_val),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Geometry base: table sectors first, then the constant part of the sum
    always_ff @(posedge i_clk) begin
        r_fat_sec <= 24'(i_geom.fat_size) * 24'(i_geom.fat_copies);
        r_base    <= i_geom.hidden + 32'(i_geom.reserved) + 32'(r_fat_sec)
                     + 32'(i_geom.root_entries[15:4]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= i_entry_index;
            r_val <= i_entry_value;
        end
        if (i_cmd.rd_en) begin
            r_bad  <= w_cur_bad;
            r_prod <= 24'(w_cl_off) * 24'(i_geom.spc);
        end
    end

    always_comb begin
        n_cur    = r_cur;
        n_active = r_active;
        if (i_cmd.start) begin
            n_cur    = i_first_cluster;
            n_active = 1'b1;
        end else if (i_cmd.emit) begin
            if (r_bad || w_is_last) begin
                n_active = 1'b0;
            end else begin
                n_cur = w_rdata;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit || i_cmd.reject) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_cluster <= r_cur;
            if (r_bad) begin
                r_sector <= '0;
                r_last   <= 1'b1;
                r_status <= ST_BAD_CLUSTER;
            end else begin
                r_sector <= r_base + 32'(r_prod);
                r_last   <= w_is_last;
                r_status <= ST_OK;
            end
        end else if (i_cmd.reject) begin
            r_sector  <= '0;
            r_cluster <= '0;
            r_last    <= 1'b0;
            r_status  <= ST_NO_CHAIN;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sector    = r_sector;
    assign o_cluster   = r_cluster;
    assign o_last      = r_last;
    assign o_status    = r_status;
endmodule

FILE: rtl/fcw_chk.sv
// Port-level checker for the cluster chain walker, bound to the top level.
// Depends on fcw_pkg and the assertion macro header.
`include "fat16_cluster_chain_sector_walker_macros.svh"

module fcw_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_ready,
    input logic [fcw_pkg::SEC_W-1:0] i_sector,
    input logic [fcw_pkg::CLU_W-1:0] i_cluster,
    input logic                      i_last,
    input logic [fcw_pkg::ST_W-1:0]  i_status
);
    import fcw_pkg::*;

    // Hold a stalled result
    `FCW_ASSERT(a_hold, (i_valid && !i_ready |=> i_valid && $stable(i_sector) && $stable(i_cluster) && $stable(i_last) && $stable(i_status)), "stalled result changed")

    // No result straight out of reset
    `FCW_ASSERT_ALWAYS(a_rst, (!i_rst_n |=> !i_valid), "result valid after reset")

    // No-chain result carries all-zero fields
    `FCW_ASSERT(a_nochain, (i_valid && i_status == ST_NO_CHAIN |-> i_sector == '0 && i_cluster == '0 && !i_last), "no-chain result not zero")

    // Bad cluster ends the chain with sector zero
    `FCW_ASSERT(a_bad, (i_valid && i_status == ST_BAD_CLUSTER |-> i_last && i_sector == '0), "bad-cluster result malformed")

    // A good result always names a data cluster
    `FCW_ASSERT(a_ok_cluster, (i_valid && i_status == ST_OK |-> i_cluster >= 16'd2), "ok result below cluster 2")
endmodule

bind fat16_cluster_chain_sector_walker fcw_chk u_fcw_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_result.valid),
    .i_ready   (o_result.ready),
    .i_sector  (o_result.sector),
    .i_cluster (o_result.cluster),
    .i_last    (o_result.last),
    .i_status  (o_result.status)
);
